// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the fall event qualifier.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== design/feq_pkg.sv =====
// Package of the fall event qualifier: widths, register indexes, reset values.
// No dependencies.
package feq_pkg;

   localparam int unsigned COORD_W = 16;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned FRAME_W = 32;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 16;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [FRAME_W-1:0] frame_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   typedef struct packed {
      coord_type height;
      coord_type width;
      coord_type y;
      coord_type x;
   } box_type;

   // register indexes
   localparam csr_idx_type CSR_COUNTING_ENABLED = 2'd0;
   localparam csr_idx_type CSR_PERSIST_THRESHOLD = 2'd1;
   localparam csr_idx_type CSR_REPEAT_GAP = 2'd2;

   // register reset values
   localparam logic RST_COUNTING_ENABLED = 1'b1;
   localparam count_type RST_PERSIST_THRESHOLD = 16'd12;
   localparam count_type RST_REPEAT_GAP = 16'd120;

   localparam count_type COUNT_MAX = '1;

endpackage

// ===== design/feq_req_if.sv =====
// Detection input channel of the fall event qualifier.
// Depends on feq_pkg.
interface feq_req_if;
   import feq_pkg::*;

   logic valid;
   logic ready;
   logic has_detection;
   logic has_class;
   coord_type box_x;
   coord_type box_y;
   coord_type box_width;
   coord_type box_height;
   logic last_in_frame;

   modport source (output valid, has_detection, has_class, box_x, box_y, box_width,
                   box_height, last_in_frame, input ready);
   modport sink (input valid, has_detection, has_class, box_x, box_y, box_width,
                 box_height, last_in_frame, output ready);
endinterface

// ===== design/feq_rsp_if.sv =====
// Per-frame result channel of the fall event qualifier.
// Depends on feq_pkg.
interface feq_rsp_if;
   import feq_pkg::*;

   logic valid;
   logic ready;
   logic fall_event;
   coord_type event_x;
   coord_type event_y;
   coord_type event_width;
   coord_type event_height;
   frame_type frame_number;

   modport source (output valid, fall_event, event_x, event_y, event_width, event_height,
                   frame_number, input ready);
   modport sink (input valid, fall_event, event_x, event_y, event_width, event_height,
                 frame_number, output ready);
endinterface

// ===== design/feq_csr_if.sv =====
// Register write channel of the fall event qualifier.
// Depends on feq_pkg.
interface feq_csr_if;
   import feq_pkg::*;

   logic valid;
   logic ready;
   csr_idx_type index;
   csr_data_type data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== design/fall_event_qualifier.sv =====
// Fall event qualifier: turns a stream of person detections into per-frame fall events.
// req_if carries one detection per beat (or one empty beat for a frame with no
// detection); last_in_frame closes the frame and produces exactly one rsp_if beat.
// csr_if writes counting_enabled / persist_threshold / repeat_gap; always ready.
// The result of a frame is registered and appears on rsp_if in the cycle after its closing beat.
// Throughput: one req beat per cycle; all per-frame math is a single pass of
// compare / increment logic between the state registers and the result register.
// Stall: the single result register holds its beat until rsp_if.ready; a new req
// beat is still taken in the cycle the held result leaves, so back-to-back
// frames flow at full rate; req_if.ready drops only while a result waits unclaimed.
// Reset (synchronous): registers go to 1 / 12 / 120, counters clear, first event
// pending, no result held. Counting disabled: req beats are taken and dropped.
// Depends on feq_pkg, the three channel interfaces and assert_macros.svh.
`include "assert_macros.svh"

module fall_event_qualifier (
   input logic         clock,
   input logic         reset,
   feq_req_if.sink     req_if,
   feq_rsp_if.source   rsp_if,
   feq_csr_if.sink     csr_if
);
   import feq_pkg::*;

   // configuration registers
   logic      enable_ff, enable_in;
   count_type thresh_ff, thresh_in;
   count_type gap_reg_ff, gap_reg_in;

   // frame state
   count_type persist_ff, persist_in;
   count_type gap_cnt_ff, gap_cnt_in;
   logic      awaiting_ff, awaiting_in;
   logic      wide_ff, wide_in;
   box_type   held_ff, held_in;
   frame_type frames_ff, frames_in;

   // result register
   logic      rsp_valid_ff, rsp_valid_in;
   logic      fall_ff, fall_in;
   box_type   ev_box_ff, ev_box_in;
   frame_type ev_frame_ff, ev_frame_in;

   logic      req_fire;
   logic      take_box;
   logic      det_wide;
   box_type   cur_box;
   logic      cur_wide;
   count_type persist_up;
   logic      first_fire;
   logic      awaiting_next;
   count_type gap_step;
   logic      gap_match;
   logic      fire;
   logic      close_frame;

   // ---------------- handshakes ----------------
   assign csr_if.ready = 1'b1;
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;
   assign close_frame  = req_fire && enable_ff && req_if.last_in_frame;

   // ---------------- register writes ----------------
   always_comb begin
      enable_in  = enable_ff;
      thresh_in  = thresh_ff;
      gap_reg_in = gap_reg_ff;
      if (csr_if.valid && csr_if.ready) begin
         unique case (csr_if.index)
            CSR_COUNTING_ENABLED:  enable_in  = csr_if.data[0];
            CSR_PERSIST_THRESHOLD: thresh_in  = csr_if.data;
            CSR_REPEAT_GAP:        gap_reg_in = csr_if.data;
            default: ;  // unmapped index, write ignored
         endcase
      end
   end

   // ---------------- detection merge ----------------
   // first wide box of the frame sticks; otherwise the latest box is kept
   assign take_box = req_if.has_detection && !wide_ff;
   assign det_wide = req_if.has_class && (req_if.box_height != '0)
                     && (req_if.box_width >= req_if.box_height);
   assign cur_box  = take_box ? box_type'{height: req_if.box_height,
                                          width: req_if.box_width,
                                          y: req_if.box_y, x: req_if.box_x}
                              : held_ff;
   assign cur_wide = wide_ff || (take_box && det_wide);

   // ---------------- frame close ----------------
   always_comb begin
      // leaky counter: up on wide frames (saturating), down otherwise (floor 0)
      persist_up = (cur_wide && (persist_ff != COUNT_MAX)) ? persist_ff + 1'b1 : persist_ff;
      first_fire = awaiting_ff && (persist_up >= thresh_ff);
      awaiting_next = awaiting_ff && !first_fire;
      // gap counter runs only once the first event is out, including its own frame
      gap_step  = gap_cnt_ff + 1'b1;
      gap_match = !awaiting_next && (gap_step == gap_reg_ff);
      fire      = first_fire || (gap_match && cur_wide);
   end

   always_comb begin
      persist_in  = persist_ff;
      gap_cnt_in  = gap_cnt_ff;
      awaiting_in = awaiting_ff;
      wide_in     = wide_ff;
      held_in     = held_ff;
      frames_in   = frames_ff;
      if (req_fire && enable_ff) begin
         if (req_if.last_in_frame) begin
            frames_in   = frames_ff + 1'b1;
            persist_in  = (!cur_wide && (persist_up != '0)) ? persist_up - 1'b1 : persist_up;
            awaiting_in = awaiting_next;
            if (!awaiting_next) begin
               gap_cnt_in = gap_match ? '0 : gap_step;
            end
            wide_in = 1'b0;
            held_in = '0;
         end else begin
            wide_in = cur_wide;
            held_in = cur_box;
         end
      end
   end

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      fall_in      = fall_ff;
      ev_box_in    = ev_box_ff;
      ev_frame_in  = ev_frame_ff;
      if (close_frame) begin
         rsp_valid_in = 1'b1;
         fall_in      = fire;
         ev_box_in    = fire ? cur_box : '0;
         ev_frame_in  = frames_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= RST_COUNTING_ENABLED;
         thresh_ff    <= RST_PERSIST_THRESHOLD;
         gap_reg_ff   <= RST_REPEAT_GAP;
         persist_ff   <= '0;
         gap_cnt_ff   <= '0;
         awaiting_ff  <= 1'b1;
         wide_ff      <= 1'b0;
         held_ff      <= '0;
         frames_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         thresh_ff    <= thresh_in;
         gap_reg_ff   <= gap_reg_in;
         persist_ff   <= persist_in;
         gap_cnt_ff   <= gap_cnt_in;
         awaiting_ff  <= awaiting_in;
         wide_ff      <= wide_in;
         held_ff      <= held_in;
         frames_ff    <= frames_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      fall_ff     <= fall_in;
      ev_box_ff   <= ev_box_in;
      ev_frame_ff <= ev_frame_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.fall_event   = fall_ff;
   assign rsp_if.event_x      = ev_box_ff.x;
   assign rsp_if.event_y      = ev_box_ff.y;
   assign rsp_if.event_width  = ev_box_ff.width;
   assign rsp_if.event_height = ev_box_ff.height;
   assign rsp_if.frame_number = ev_frame_ff;

   // ---------------- checks ----------------
   // no box reported without an event
   `ASSERT_IMPLY(a_box_zero_no_event, clock, reset,
                 rsp_valid_ff && !fall_ff, ev_box_ff == '0)
   // a closed frame always yields a result next cycle
   `ASSERT_NEXT(a_close_gives_rsp, clock, reset, close_frame, rsp_valid_ff)
   // the first event happens once only
   `ASSERT_NEXT(a_first_once, clock, reset, !awaiting_ff, !awaiting_ff)
   // the persistence counter moves by at most one per cycle
   `ASSERT_NEXT(a_persist_step, clock, reset, 1'b1,
                (persist_ff == $past(persist_ff)) ||
                (persist_ff == $past(persist_ff) + 16'd1) ||
                (persist_ff == $past(persist_ff) - 16'd1))
   // the frame count advances only on a closed frame
   `ASSERT_NEXT(a_frames_hold, clock, reset, !close_frame, frames_ff == $past(frames_ff))

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for fall_event_qualifier: random and directed detection beats,
// per-frame results checked against an in-bench model. Needs feq_pkg and the channel interfaces.
module tb_top;
   import feq_pkg::*;

   // one detection beat as the bench queues it
   typedef struct packed {
      logic    has_det;
      logic    has_cls;
      box_type box;
      logic    last;
   } det_beat;

   // one per-frame result the model predicts
   typedef struct packed {
      logic      fall;
      box_type   box;
      frame_type frame;
   } frame_result;

   localparam int unsigned IDLE_PCT = 36;    // idle cycles per hundred on each side
   localparam int unsigned HOLD_LEN = 80;    // long receiver hold-off
   localparam int unsigned SETTLE = 4;       // result appears in the cycle after its closing beat

   logic clock;
   logic reset;

   feq_req_if req_if ();
   feq_rsp_if rsp_if ();
   feq_csr_if csr_if ();

   fall_event_qualifier u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // ---------------------------------------------------------------------------------------
   // Qualifier model: register copies and frame state
   // ---------------------------------------------------------------------------------------
   logic      cfg_counting;
   count_type cfg_threshold;
   count_type cfg_gap;

   count_type persist_cnt;
   count_type gap_cnt;
   logic      first_pending;
   logic      frame_wide;
   box_type   frame_box;
   frame_type frames_seen;

   frame_result expected_frames[$];
   det_beat     pending_beats[$];

   int unsigned n_pushed;
   int unsigned n_accepted;
   int unsigned n_errors;
   int unsigned n_printed;

   logic        req_taken;    // req beat went through at the last rising edge
   logic        steady;       // no idling on either side while set
   logic        hold_req;     // toggled by the stimulus to ask for a long hold-off
   logic        hold_ack;
   int unsigned hold_left;
   det_beat     drv_beat;

   function automatic void clear_model();
      cfg_counting = RST_COUNTING_ENABLED;
      cfg_threshold = RST_PERSIST_THRESHOLD;
      cfg_gap = RST_REPEAT_GAP;
      persist_cnt = '0;
      gap_cnt = '0;
      first_pending = 1'b1;
      frame_wide = 1'b0;
      frame_box = '0;
      frames_seen = '0;
   endfunction

   function automatic void apply_csr(csr_idx_type idx, csr_data_type val);
      case (idx)
         CSR_COUNTING_ENABLED: cfg_counting = val[0];
         CSR_PERSIST_THRESHOLD: cfg_threshold = val;
         CSR_REPEAT_GAP: cfg_gap = val;
         default: ;
      endcase
   endfunction

   // Folds an accepted beat into the frame if counting is on; a closing beat yields one result.
   function automatic void qualify_detection(det_beat b);
      frame_result r;
      logic        was_wide;
      logic        fire;
      if (!cfg_counting) return;
      // first wide box of the frame sticks; until then the latest box is held
      if (b.has_det && !frame_wide) begin
         frame_box = b.box;
         if (b.has_cls && b.box.height != '0 && b.box.width >= b.box.height)
            frame_wide = 1'b1;
      end
      if (!b.last) return;

      frames_seen = frames_seen + 1'b1;
      was_wide = frame_wide;
      if (was_wide && persist_cnt != COUNT_MAX) persist_cnt = persist_cnt + 1'b1;
      fire = 1'b0;
      if (persist_cnt >= cfg_threshold && first_pending) begin
         first_pending = 1'b0;
         fire = 1'b1;
      end
      // leak happens after the threshold compare
      if (!was_wide && persist_cnt != '0) persist_cnt = persist_cnt - 1'b1;
      if (!first_pending) begin
         gap_cnt = gap_cnt + 1'b1;    // 16-bit, wraps on purpose
         if (gap_cnt == cfg_gap) begin
            if (was_wide) fire = 1'b1;
            gap_cnt = '0;
         end
      end

      r.fall = fire;
      r.box = fire ? frame_box : '0;
      r.frame = frames_seen;
      expected_frames.push_back(r);
      frame_wide = 1'b0;
      frame_box = '0;
   endfunction

   function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         n_errors++;
         if (n_printed < 100) begin
            n_printed++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
         end
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Clock and reset
   // ---------------------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Rising edge: register writes, result check, then prediction of the accepted beat.
   // A result never shares an edge with its own closing beat, so this order is safe.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      frame_result want;
      req_taken <= !reset && req_if.valid && req_if.ready;
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) apply_csr(csr_if.index, csr_if.data);
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_frames.size() == 0) begin
               n_errors++;
               if (n_printed < 100) begin
                  n_printed++;
                  $display("%0t: unexpected result beat, expected none, actual frame %0d",
                           $time, rsp_if.frame_number);
               end
            end else begin
               want = expected_frames.pop_front();
               check_field("fall_event", want.fall, rsp_if.fall_event);
               check_field("event_x", want.box.x, rsp_if.event_x);
               check_field("event_y", want.box.y, rsp_if.event_y);
               check_field("event_width", want.box.width, rsp_if.event_width);
               check_field("event_height", want.box.height, rsp_if.event_height);
               check_field("frame_number", want.frame, rsp_if.frame_number);
            end
         end
         if (req_if.valid && req_if.ready) begin
            n_accepted++;
            qualify_detection({req_if.has_detection, req_if.has_class,
                               {req_if.box_height, req_if.box_width, req_if.box_y,
                                req_if.box_x},
                               req_if.last_in_frame});
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Detection driver: falling edge, fed from pending_beats, idles at random
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (pending_beats.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            drv_beat = pending_beats.pop_front();
            req_if.valid <= 1'b1;
            req_if.has_detection <= drv_beat.has_det;
            req_if.has_class <= drv_beat.has_cls;
            req_if.box_x <= drv_beat.box.x;
            req_if.box_y <= drv_beat.box.y;
            req_if.box_width <= drv_beat.box.width;
            req_if.box_height <= drv_beat.box.height;
            req_if.last_in_frame <= drv_beat.last;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result receiver: random back-pressure plus an occasional long hold-off, which fills
   // the single result register and stalls the input side
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack <= hold_req;
         hold_left <= HOLD_LEN;
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------
   function automatic det_beat mk(logic has_det, logic has_cls, coord_type x, coord_type y,
                                  coord_type w, coord_type h, logic last);
      det_beat b;
      b.has_det = has_det;
      b.has_cls = has_cls;
      b.box.x = x;
      b.box.y = y;
      b.box.width = w;
      b.box.height = h;
      b.last = last;
      return b;
   endfunction

   // sizes: full range, small boxes, or the corner values
   function automatic coord_type rand_dim();
      coord_type corners[4] = '{16'h0000, 16'h0001, 16'hFFFE, 16'hFFFF};
      case ($urandom_range(3))
         0: return coord_type'($urandom_range(0, 64));
         1: return corners[$urandom_range(3)];
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic void make_narrow(ref det_beat b);
      b.has_det = 1'b1;
      case ($urandom_range(2))
         0: begin    // no classification
            b.has_cls = 1'b0;
            b.box.width = rand_dim();
            b.box.height = rand_dim();
         end
         1: begin    // zero height
            b.has_cls = 1'b1;
            b.box.width = rand_dim();
            b.box.height = '0;
         end
         default: begin    // taller than wide
            b.has_cls = 1'b1;
            b.box.height = rand_dim();
            if (b.box.height == '0) b.box.height = 16'd1;
            b.box.width = coord_type'($urandom_range(0, b.box.height - 1));
         end
      endcase
   endfunction

   function automatic void make_wide(ref det_beat b);
      b.has_det = 1'b1;
      b.has_cls = 1'b1;
      b.box.height = rand_dim();
      if (b.box.height == '0) b.box.height = 16'd1;
      b.box.width = coord_type'($urandom_range(b.box.height, 16'hFFFF));
   endfunction

   task automatic push_beat(det_beat b);
      pending_beats.push_back(b);
      n_pushed++;
   endtask

   // One frame of 1..4 beats. wide_pct: chance the frame holds a wide box.
   task automatic push_frame(int unsigned wide_pct, bit single);
      int unsigned n;
      int unsigned wide_at;
      bit          want_wide;
      det_beat     b;
      n = single ? 1 : $urandom_range(1, 4);
      if (!single && $urandom_range(99) < 8) begin
         // empty frame: one beat with no detection
         b = mk(1'b0, 1'($urandom), coord_type'($urandom), coord_type'($urandom),
                coord_type'($urandom), coord_type'($urandom), 1'b1);
         push_beat(b);
         return;
      end
      want_wide = $urandom_range(99) < wide_pct;
      wide_at = $urandom_range(0, n - 1);
      for (int unsigned i = 0; i < n; i++) begin
         b = mk(1'b1, 1'($urandom), coord_type'($urandom), coord_type'($urandom),
                coord_type'($urandom), coord_type'($urandom), i == n - 1);
         if (!single && i != 0 && $urandom_range(99) < 10) b.has_det = 1'b0;
         else if (!want_wide || i < wide_at) make_narrow(b);
         else if (i == wide_at) make_wide(b);
         // beats after the wide one stay fully random: their boxes must be ignored
         push_beat(b);
      end
   endtask

   task automatic push_frames(int unsigned n_beats, int unsigned wide_pct, bit single);
      int unsigned stop_at;
      stop_at = n_pushed + n_beats;
      @(posedge clock);
      while (n_pushed < stop_at) push_frame(wide_pct, single);
   endtask

   // all beats in, all results out, then a settling wait for any frame still in flight
   task automatic wait_idle();
      @(negedge clock);
      while (n_accepted != n_pushed || expected_frames.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, csr_data_type val);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= val;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic long_hold();
      @(posedge clock);
      hold_req <= ~hold_req;
   endtask

   // ---------------------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.has_detection = 1'b0;
      req_if.has_class = 1'b0;
      req_if.box_x = '0;
      req_if.box_y = '0;
      req_if.box_width = '0;
      req_if.box_height = '0;
      req_if.last_in_frame = 1'b0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_COUNTING_ENABLED;
      csr_if.data = '0;
      req_taken = 1'b0;
      steady = 1'b0;
      hold_req = 1'b0;
      hold_ack = 1'b0;
      hold_left = 0;
      n_pushed = 0;
      n_accepted = 0;
      n_errors = 0;
      n_printed = 0;
      clear_model();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames at the reset register values
      @(posedge clock);
      push_beat(mk(1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));  // empty frame
      push_beat(mk(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));  // square, max
      push_beat(mk(1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));  // zero height
      push_beat(mk(1'b1, 1'b0, 16'h0010, 16'h0020, 16'hFFFF, 16'h0001, 1'b1));  // no class
      push_beat(mk(1'b1, 1'b1, 16'h0005, 16'h0006, 16'h0009, 16'h000A, 1'b1));  // just too tall
      // narrow, then wide (kept), then a later wide box that must be ignored
      push_beat(mk(1'b1, 1'b1, 16'h0001, 16'h0002, 16'h0001, 16'h0002, 1'b0));
      push_beat(mk(1'b1, 1'b1, 16'h1234, 16'h5678, 16'h0064, 16'h0032, 1'b0));
      push_beat(mk(1'b1, 1'b1, 16'hAAAA, 16'h5555, 16'h8000, 16'h0001, 1'b1));
      // wide box, then an empty closing beat that must not overwrite it
      push_beat(mk(1'b1, 1'b1, 16'h0100, 16'h0200, 16'h0040, 16'h0040, 1'b0));
      push_beat(mk(1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 1'b1));
      // narrow, hole, narrow: last detection is the frame box
      push_beat(mk(1'b1, 1'b0, 16'h0011, 16'h0022, 16'h0033, 16'h0044, 1'b0));
      push_beat(mk(1'b0, 1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b0));
      push_beat(mk(1'b1, 1'b1, 16'h0055, 16'h0066, 16'h0002, 16'h0003, 1'b1));
      push_beat(mk(1'b1, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b1));  // zero height
      push_beat(mk(1'b0, 1'b1, 16'h1357, 16'h2468, 16'h0003, 16'h0002, 1'b1));  // no detection
      push_beat(mk(1'b1, 1'b1, 16'h0000, 16'hFFFF, 16'h0001, 16'h0001, 1'b1));  // 1x1 wide
      push_beat(mk(1'b1, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFE, 1'b1));
      wait_idle();

      // Register extremes: first event out of reach
      write_reg(CSR_PERSIST_THRESHOLD, 16'hFFFF);
      write_reg(CSR_REPEAT_GAP, 16'hFFFF);
      push_frames(60, 85, 1'b0);
      wait_idle();

      // Counting off: every beat dropped, no result
      write_reg(CSR_COUNTING_ENABLED, 1'b0);
      push_frames(60, 50, 1'b0);
      wait_idle();

      // Main random run: leaky build-up to the first event, then a repeat chance every 7 frames
      write_reg(CSR_COUNTING_ENABLED, 1'b1);
      write_reg(CSR_PERSIST_THRESHOLD, 16'd20);
      write_reg(CSR_REPEAT_GAP, 16'd7);
      push_frames(450, 65, 1'b0);
      long_hold();    // receiver stalls while the driver keeps offering beats
      wait_idle();    // sender held until every result is back

      // Full-rate stretch, every wide frame a chance; threshold 0 has no effect by now
      write_reg(CSR_REPEAT_GAP, 16'd1);
      write_reg(CSR_PERSIST_THRESHOLD, 16'd0);
      @(posedge clock);
      steady <= 1'b1;
      push_frames(300, 50, 1'b0);
      wait_idle();
      @(posedge clock);
      steady <= 1'b0;

      write_reg(CSR_REPEAT_GAP, 16'd3);
      write_reg(CSR_PERSIST_THRESHOLD, 16'd1);
      push_frames(300, 55, 1'b0);
      long_hold();
      wait_idle();

      // Gap counter overtakes a lowered gap: set gap 0 once the counter is well past it,
      // so no repeat event fires before the 16-bit wrap
      write_reg(CSR_REPEAT_GAP, 16'd200);
      push_frames(50, 50, 1'b1);
      wait_idle();
      write_reg(CSR_REPEAT_GAP, 16'd0);
      @(posedge clock);
      steady <= 1'b1;
      push_frames(100, 90, 1'b1);
      wait_idle();
      @(posedge clock);
      steady <= 1'b0;

      // Closing random run, a repeat chance every 4 frames
      write_reg(CSR_REPEAT_GAP, RST_REPEAT_GAP);
      write_reg(CSR_PERSIST_THRESHOLD, RST_PERSIST_THRESHOLD);
      write_reg(CSR_REPEAT_GAP, 16'd4);
      push_frames(300, 60, 1'b0);
      long_hold();
      wait_idle();

      // counting off again at the end
      write_reg(CSR_COUNTING_ENABLED, 1'b0);
      push_frames(20, 50, 1'b0);
      wait_idle();

      repeat (8) @(posedge clock);
      if (n_errors == 0)
         $display("fall_event_qualifier test passed");
      else
         $display("fall_event_qualifier test failed");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #8_000_000;
      $display("fall_event_qualifier test failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/feq_pkg.sv
design/feq_req_if.sv
design/feq_rsp_if.sv
design/feq_csr_if.sv
design/fall_event_qualifier.sv
verif/tb_top.sv
